// ===== sv/rrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared types and constants for the receive reorder window.
// ----------------------------------------------------------------------------
package rrw_pkg;

    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 10;
    localparam int SPACE_W = 16;
    localparam int WIN_W   = 6;
    localparam int SLOT_W  = 5;

    localparam int HEADER_BYTES   = 16;
    localparam int MAX_PAYLOAD    = 1000;
    localparam int MAX_WINDOW_DEF = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_RETRY  = 1'b1;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EVAL,
        ST_ACK
    } rrw_state_t;

endpackage

// ===== sv/rrw_pkt_if.sv =====
// ----------------------------------------------------------------------------
// rrw_pkt_if
// Packet event channel: one transaction per arrival or retry.
// ----------------------------------------------------------------------------
interface rrw_pkt_if;
    import rrw_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [SEQ_W-1:0]   seq_number;
    logic [LEN_W-1:0]   packet_length;
    logic               length_matches;
    logic               checksum_ok;
    logic [SPACE_W-1:0] output_space;

    modport source (
        output valid, func, seq_number, packet_length, length_matches,
               checksum_ok, output_space,
        input  ready
    );

    modport sink (
        input  valid, func, seq_number, packet_length, length_matches,
               checksum_ok, output_space,
        output ready
    );
endinterface

// ===== sv/rrw_res_if.sv =====
// ----------------------------------------------------------------------------
// rrw_res_if
// Result channel: one transaction per delivery or cumulative ack.
// ----------------------------------------------------------------------------
interface rrw_res_if;
    import rrw_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SEQ_W-1:0]  sequence_value;
    logic [SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]  byte_count;
    logic              end_of_stream;
    logic              last;

    modport source (
        output valid, kind, sequence_value, slot_index, byte_count,
               end_of_stream, last,
        input  ready
    );

    modport sink (
        input  valid, kind, sequence_value, slot_index, byte_count,
               end_of_stream, last,
        output ready
    );
endinterface

// ===== sv/receive_reorder_window.sv =====
// ----------------------------------------------------------------------------
// receive_reorder_window
// Receive side of a sliding-window transport with selective-repeat buffering.
// ----------------------------------------------------------------------------
// A packet transaction that passes its checks is recorded in slot
// seq mod MAX_WINDOW when it falls inside the window; packets are then
// released in sequence order while the output space exceeds their byte
// count, and every accepted transaction ends with one cumulative ack.
// A dropped packet produces nothing. Payload bytes stay in an external
// buffer addressed by slot_index. Per-slot length and EOF flag live in a
// synchronous memory with a registered read, so a transaction steps through
// capture, check and the first slot read, then one read and evaluation per
// released packet, then the final slot evaluation and the ack; it waits
// while the result side stalls. A dropped packet goes from the check back
// to idle. A new transaction is taken only after the ack has been loaded
// into the output register, or after a packet has been dropped.
// ----------------------------------------------------------------------------
module receive_reorder_window #(
    parameter int MAX_WINDOW = rrw_pkg::MAX_WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rrw_pkg::WIN_W-1:0]  cfg_wdata,
    rrw_pkt_if.sink                    pkt,
    rrw_res_if.source                  res
);
    import rrw_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = AW + 1;
    localparam int MW = LEN_W + 1;
    localparam logic [AW-1:0]    SLOT_RESET = AW'(1 % MAX_WINDOW);
    localparam logic [AW-1:0]    SLOT_LAST  = AW'(MAX_WINDOW - 1);
    localparam logic [SW-1:0]    WIN_SW     = SW'(MAX_WINDOW);
    localparam logic [SEQ_W-1:0] WIN_SEQ    = SEQ_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(HEADER_BYTES + MAX_PAYLOAD);

    rrw_state_t state_reg, state_next;

    logic [WIN_W-1:0]      window_reg;
    logic [SEQ_W-1:0]      next_expected_reg, next_expected_next;
    logic [AW-1:0]         next_slot_reg, next_slot_next;
    logic                  finished_reg, finished_next;
    logic [MAX_WINDOW-1:0] slot_valid_reg, slot_valid_next;

    logic                  func_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  len_ok_reg;
    logic                  ck_ok_reg;
    logic [SPACE_W-1:0]    space_reg, space_next;

    logic [MW-1:0]         mem [MAX_WINDOW];
    logic [MW-1:0]         rd_data_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [SEQ_W-1:0]      out_seq_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [LEN_W-1:0]      out_bytes_reg;
    logic                  out_eos_reg;
    logic                  out_last_reg;

    logic                  drop;
    logic [SEQ_W-1:0]      offset;
    logic                  in_window;
    logic [SW-1:0]         slot_sum;
    logic [SW-1:0]         slot_wrap;
    logic [AW-1:0]         arr_slot;
    logic                  slot_free;
    logic [LEN_W-1:0]      rd_bytes;
    logic                  rd_eof;
    logic                  releasable;
    logic                  out_free;
    logic [AW+SLOT_W-1:0]  slot_wide;

    logic                  take;
    logic                  do_store;
    logic                  rd_en;
    logic                  do_deliver;
    logic                  do_ack;

    // Datapath terms
    assign drop = (func_reg == FUNC_ARRIVE) &&
                  (!len_ok_reg || !ck_ok_reg || (len_reg < LEN_MIN) ||
                   (len_reg > LEN_MAX) || finished_reg);
    assign offset    = seq_reg - next_expected_reg;
    assign in_window = (offset < {{(SEQ_W-WIN_W){1'b0}}, window_reg}) &&
                       (offset < WIN_SEQ);
    assign slot_sum  = {1'b0, next_slot_reg} + {1'b0, offset[AW-1:0]};
    assign slot_wrap = (slot_sum >= WIN_SW) ? (slot_sum - WIN_SW) : slot_sum;
    assign arr_slot  = slot_wrap[AW-1:0];
    assign slot_free = !slot_valid_reg[arr_slot];

    assign rd_bytes   = rd_data_reg[LEN_W-1:0];
    assign rd_eof     = rd_data_reg[LEN_W];
    assign releasable = slot_valid_reg[next_slot_reg] &&
                        ({{(SPACE_W-LEN_W){1'b0}}, rd_bytes} < space_reg);
    assign out_free   = !out_valid_reg || res.ready;
    assign slot_wide  = {{SLOT_W{1'b0}}, next_slot_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pkt.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = drop ? ST_IDLE : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!releasable)
                begin
                    state_next = ST_ACK;
                end
                else if (out_free)
                begin
                    state_next = ST_READ;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        take       = 1'b0;
        do_store   = 1'b0;
        rd_en      = 1'b0;
        do_deliver = 1'b0;
        do_ack     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                take = pkt.valid;
            end
            ST_CHECK:
            begin
                do_store = (func_reg == FUNC_ARRIVE) && !drop && in_window && slot_free;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_EVAL:
            begin
                do_deliver = releasable && out_free;
            end
            ST_ACK:
            begin
                do_ack = out_free;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    assign pkt.ready = (state_reg == ST_IDLE);

    // Window state updates
    always_comb
    begin
        next_expected_next = next_expected_reg;
        next_slot_next     = next_slot_reg;
        finished_next      = finished_reg;
        slot_valid_next    = slot_valid_reg;
        space_next         = space_reg;
        if (do_store)
        begin
            slot_valid_next[arr_slot] = 1'b1;
        end
        if (do_deliver)
        begin
            slot_valid_next[next_slot_reg] = 1'b0;
            next_expected_next = next_expected_reg + SEQ_W'(1);
            next_slot_next     = (next_slot_reg == SLOT_LAST) ? '0 : next_slot_reg + AW'(1);
            space_next         = space_reg - {{(SPACE_W-LEN_W){1'b0}}, rd_bytes};
            if (rd_eof)
            begin
                finished_next = 1'b1;
            end
        end
        if (take)
        begin
            space_next = pkt.output_space;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_reg        <= WINDOW_RESET;
            next_expected_reg <= SEQ_W'(1);
            next_slot_reg     <= SLOT_RESET;
            finished_reg      <= 1'b0;
            slot_valid_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            next_expected_reg <= next_expected_next;
            next_slot_reg     <= next_slot_next;
            finished_reg      <= finished_next;
            slot_valid_reg    <= slot_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (do_deliver || do_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction and load the result register
    always_ff @(posedge clk)
    begin
        space_reg <= space_next;
        if (take)
        begin
            func_reg   <= pkt.func;
            seq_reg    <= pkt.seq_number;
            len_reg    <= pkt.packet_length;
            len_ok_reg <= pkt.length_matches;
            ck_ok_reg  <= pkt.checksum_ok;
        end
        if (do_deliver)
        begin
            out_kind_reg  <= KIND_DELIVER;
            out_seq_reg   <= next_expected_reg;
            out_slot_reg  <= slot_wide[SLOT_W-1:0];
            out_bytes_reg <= rd_bytes;
            out_eos_reg   <= rd_eof;
            out_last_reg  <= 1'b0;
        end
        else if (do_ack)
        begin
            out_kind_reg  <= KIND_ACK;
            out_seq_reg   <= next_expected_reg;
            out_slot_reg  <= '0;
            out_bytes_reg <= '0;
            out_eos_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    // Slot memory: byte count and EOF flag per slot
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            mem[arr_slot] <= {(len_reg == LEN_MIN), len_reg - LEN_MIN};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[next_slot_reg];
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_kind_reg;
    assign res.sequence_value = out_seq_reg;
    assign res.slot_index     = out_slot_reg;
    assign res.byte_count     = out_bytes_reg;
    assign res.end_of_stream  = out_eos_reg;
    assign res.last           = out_last_reg;

`ifndef SYNTHESIS
    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.last == (res.kind == KIND_ACK)))
        else $error("last flag disagrees with result kind");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg <= SLOT_LAST)
        else $error("slot pointer beyond window");

    a_deliver_advances: assert property (@(posedge clk) disable iff (!rst_n)
        do_deliver |=> (next_expected_reg == $past(next_expected_reg) + SEQ_W'(1)))
        else $error("delivery did not advance next expected");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pkt.ready)
        else $error("packet channel ready while busy");
`endif

endmodule

// ===== tb/tb_receive_reorder_window.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_receive_reorder_window
// Self-checking testbench for the receive reorder window.
// ----------------------------------------------------------------------------
// Packet and retry transactions are driven on the packet channel. A
// behavioral predictor tracks the window, the slot store and the stream
// state, and queues the deliveries and the cumulative ack expected for each
// accepted transaction. A checker compares every result transaction with the
// oldest queued one. The run covers drop conditions, window edges,
// duplicates, exact-space release, a full 32-slot release, end of stream and
// random traffic under several window settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_receive_reorder_window;
    import rrw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_GAP = 40;
    localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  bytes;
        logic              eos;
        logic              last;
    } rrw_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    rrw_pkt_if pkt_bus();
    rrw_res_if res_bus();

    receive_reorder_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pkt       (pkt_bus),
        .res       (res_bus)
    );

    rrw_result_t expected_results[$];
    int error_count;
    int cycle_count;
    int idle_pct;
    int stall_pct;

    logic [WIN_W-1:0]  window_reg;
    logic [SEQ_W-1:0]  next_seq;
    bit                stream_done;
    bit                slot_held [MAX_WINDOW_DEF];
    logic [LEN_W-1:0]  slot_len [MAX_WINDOW_DEF];
    bit                slot_eof [MAX_WINDOW_DEF];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH %s: expected %0h got %0h (cycle %0d)",
                     what, want, got, cycle_count);
    endtask

    always @(posedge clk)
    begin
        rrw_result_t got;
        rrw_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.kind, res_bus.sequence_value, res_bus.slot_index,
                    res_bus.byte_count, res_bus.end_of_stream, res_bus.last};
            if (expected_results.size() == 0)
                report_mismatch("unexpected result seq", 32'd0, got.seq);
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", want.kind, got.kind);
                if (got.seq !== want.seq)
                    report_mismatch("sequence_value", want.seq, got.seq);
                if (got.slot !== want.slot)
                    report_mismatch("slot_index", want.slot, got.slot);
                if (got.bytes !== want.bytes)
                    report_mismatch("byte_count", want.bytes, got.bytes);
                if (got.eos !== want.eos)
                    report_mismatch("end_of_stream", want.eos, got.eos);
                if (got.last !== want.last)
                    report_mismatch("last", want.last, got.last);
            end
        end
    end

    // Update the receiver state for one transaction; queue its results.
    // Return 0 when the packet is dropped without any result.
    function automatic bit predict_reorder(input logic fn, input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] len,
                                           input logic len_ok, input logic ck_ok,
                                           input logic [SPACE_W-1:0] space);
        int unsigned win;
        logic [SEQ_W-1:0] offset;
        logic [SLOT_W-1:0] s;
        int avail;
        if (fn == FUNC_ARRIVE)
        begin
            if (!len_ok || !ck_ok || len < HEADER_BYTES ||
                len > HEADER_BYTES + MAX_PAYLOAD || stream_done)
                return 1'b0;
            win = (window_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_reg;
            offset = seq - next_seq;
            s = seq[SLOT_W-1:0];
            if (offset < win && !slot_held[s])
            begin
                slot_held[s] = 1'b1;
                slot_len[s] = LEN_W'(len - HEADER_BYTES);
                slot_eof[s] = (len == HEADER_BYTES);
            end
        end
        avail = int'(space);
        for (int k = 0; k < MAX_WINDOW_DEF; k++)
        begin
            s = next_seq[SLOT_W-1:0];
            if (!slot_held[s] || !(avail > slot_len[s]))
                break;
            avail -= slot_len[s];
            expected_results.push_back('{KIND_DELIVER, next_seq, s, slot_len[s],
                                         slot_eof[s], 1'b0});
            if (slot_eof[s])
                stream_done = 1'b1;
            slot_held[s] = 1'b0;
            next_seq++;
        end
        expected_results.push_back('{KIND_ACK, next_seq, '0, '0, 1'b0, 1'b1});
        return 1'b1;
    endfunction

    task automatic send_item(input logic fn, input logic [SEQ_W-1:0] seq,
                             input logic [LEN_W-1:0] len, input logic len_ok,
                             input logic ck_ok, input logic [SPACE_W-1:0] space,
                             output bit counted);
        int gap;
        gap = 0;
        @(negedge clk);
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            pkt_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_bus.func           <= fn;
        pkt_bus.seq_number     <= seq;
        pkt_bus.packet_length  <= len;
        pkt_bus.length_matches <= len_ok;
        pkt_bus.checksum_ok    <= ck_ok;
        pkt_bus.output_space   <= space;
        pkt_bus.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!(pkt_bus.valid && pkt_bus.ready));
        counted = predict_reorder(fn, seq, len, len_ok, ck_ok, space);
    endtask

    task automatic arrive(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                          input logic [SPACE_W-1:0] space);
        bit counted;
        send_item(FUNC_ARRIVE, seq, len, 1'b1, 1'b1, space, counted);
    endtask

    task automatic retry(input logic [SPACE_W-1:0] space);
        bit counted;
        send_item(FUNC_RETRY, $urandom, LEN_W'($urandom_range(0, 1023)),
                  1'($urandom), 1'($urandom), space, counted);
    endtask

    // Hold the packet channel idle until every queued result has arrived.
    task automatic wait_drain();
        @(negedge clk);
        pkt_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        window_reg = value;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin idle_pct = 86; stall_pct = 0;  end
            IDLE_RECV: begin idle_pct = 0;  stall_pct = 86; end
            default:   begin idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    function automatic logic [SPACE_W-1:0] pick_space();
        case ($urandom_range(3))
            0: return '0;
            1: return SPACE_W'($urandom_range(0, 1100));
            2: return SPACE_W'($urandom);
            default: return SPACE_MAX;
        endcase
    endfunction

    task automatic random_item(output bit counted);
        int unsigned win;
        int pick;
        logic [LEN_W-1:0] len;
        logic len_ok;
        logic ck_ok;
        win = (window_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_reg;
        pick = $urandom_range(99);
        len = ($urandom_range(4) == 0) ? LEN_W'($urandom_range(17, 1016))
                                       : LEN_W'($urandom_range(17, 116));
        if (pick < 65)
            send_item(FUNC_ARRIVE, next_seq + $urandom_range(0, win + 1), len,
                      1'b1, 1'b1, pick_space(), counted);
        else if (pick < 80)
            send_item(FUNC_RETRY, $urandom, LEN_W'($urandom), 1'($urandom),
                      1'($urandom), pick_space(), counted);
        else if (pick < 85)
            send_item(FUNC_ARRIVE, next_seq - $urandom_range(1, 40), len,
                      1'b1, 1'b1, pick_space(), counted);
        else
        begin
            len = LEN_W'($urandom);
            len_ok = 1'($urandom);
            ck_ok = 1'($urandom);
            if (len == HEADER_BYTES)
                ck_ok = 1'b0;
            send_item(FUNC_ARRIVE, $urandom, len, len_ok, ck_ok, SPACE_W'($urandom),
                      counted);
        end
    endtask

    task automatic run_random_phase(input logic [WIN_W-1:0] window,
                                    input idle_mode_t mode, input int target);
        int done_count;
        bit counted;
        write_window(window);
        set_idling(mode);
        done_count = 0;
        while (done_count < target)
        begin
            random_item(counted);
            if (counted)
                done_count++;
        end
        wait_drain();
    endtask

    task automatic test_directed_cases();
        logic [SEQ_W-1:0] base;
        bit counted;
        set_idling(IDLE_NONE);
        base = next_seq;
        send_item(FUNC_ARRIVE, base, 10'd20, 1'b0, 1'b1, SPACE_MAX, counted);
        send_item(FUNC_ARRIVE, base, 10'd20, 1'b1, 1'b0, SPACE_MAX, counted);
        arrive(base, 10'd15, SPACE_MAX);
        arrive(base, 10'd0, SPACE_MAX);
        arrive(base, 10'd1017, SPACE_MAX);
        arrive(base, 10'd1023, SPACE_MAX);
        retry('0);
        arrive(32'h0000_0000, 10'd17, SPACE_MAX);
        arrive(32'hFFFF_FFFF, 10'd1016, SPACE_MAX);
        arrive(base + window_reg, 10'd40, SPACE_MAX);
        arrive(base + window_reg - 1, 10'd17, '0);
        arrive(base, 10'd1016, SPACE_MAX);
        base = next_seq;
        arrive(base + 1, 10'd50, '0);
        arrive(base + 1, 10'd60, '0);
        arrive(base, 10'd116, 16'd100);
        retry(16'd101);
        retry(SPACE_MAX);
        arrive(next_seq, 10'd1016, 16'd1000);
        retry(16'd1001);
        wait_drain();
    endtask

    task automatic test_full_window_release();
        logic [SEQ_W-1:0] base;
        write_window(WIN_W'(MAX_WINDOW_DEF));
        set_idling(IDLE_BOTH);
        base = next_seq;
        for (int k = 0; k < MAX_WINDOW_DEF; k++)
            arrive(base + k, LEN_W'($urandom_range(17, 1016)), '0);
        retry(SPACE_MAX);
        wait_drain();
    endtask

    task automatic test_end_of_stream();
        logic [SEQ_W-1:0] base;
        write_window(WINDOW_RESET);
        set_idling(IDLE_RECV);
        base = next_seq;
        arrive(base + 1, LEN_W'($urandom_range(17, 1016)), '0);
        arrive(base + 2, LEN_W'(HEADER_BYTES), '0);
        arrive(base + 4, LEN_W'($urandom_range(17, 1016)), '0);
        arrive(base, LEN_W'(HEADER_BYTES), '0);
        retry(16'd1);
        retry(SPACE_MAX);
        arrive(base + 3, 10'd100, SPACE_MAX);
        arrive(base + 5, LEN_W'(HEADER_BYTES), SPACE_MAX);
        retry('0);
        retry(SPACE_MAX);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(WIN_W'(63), IDLE_NONE, 14);
        run_random_phase(WIN_W'(1), IDLE_SEND, 11);
        run_random_phase(WIN_W'(0), IDLE_RECV, 5);
        run_random_phase(WIN_W'(MAX_WINDOW_DEF), IDLE_RECV, 11);
        run_random_phase(WIN_W'($urandom_range(2, 31)), IDLE_BOTH, 14);
        run_random_phase(WINDOW_RESET, IDLE_NONE, 5);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        pkt_bus.valid          = 1'b0;
        pkt_bus.func           = FUNC_ARRIVE;
        pkt_bus.seq_number     = '0;
        pkt_bus.packet_length  = '0;
        pkt_bus.length_matches = 1'b0;
        pkt_bus.checksum_ok    = 1'b0;
        pkt_bus.output_space   = '0;
        res_bus.ready          = 1'b0;
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        window_reg  = WINDOW_RESET;
        next_seq    = 32'd1;
        stream_done = 1'b0;
        for (int k = 0; k < MAX_WINDOW_DEF; k++)
        begin
            slot_held[k] = 1'b0;
            slot_len[k]  = '0;
            slot_eof[k]  = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_full_window_release();
        test_end_of_stream();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
